// File: hdl/lrfp_pkg.sv
`default_nettype none

package lrfp_pkg;

	localparam logic [7:0] HEAD_MEAS   = 8'hAA;
	localparam logic [7:0] HEAD_ERR    = 8'hEE;
	localparam logic [7:0] ZERO_BYTE   = 8'h00;
	localparam logic [7:0] CMD_BYTE    = 8'h22;

	localparam logic [7:0] IDX_HEAD       = 8'd0;
	localparam logic [7:0] IDX_ADDR       = 8'd1;
	localparam logic [7:0] IDX_ZERO       = 8'd2;
	localparam logic [7:0] IDX_CMD        = 8'd3;
	localparam logic [7:0] IDX_DIST_FIRST = 8'd6;
	localparam logic [7:0] IDX_DIST_LAST  = 8'd9;
	localparam logic [7:0] IDX_CODE_FIRST = 8'd6;
	localparam logic [7:0] IDX_CODE_LAST  = 8'd7;
	localparam logic [7:0] IDX_SAT        = 8'hFF;

	// Index of the final byte for the shortest frame and shortest measurement.
	localparam logic [7:0] IDX_MIN_LAST      = 8'd8;
	localparam logic [7:0] IDX_MEAS_MIN_LAST = 8'd12;

	localparam logic [7:0] MAX_LEN_RESET = 8'd64;

	typedef enum logic {
		REG_DEVICE_ADDRESS = 1'b0,
		REG_MAX_FRAME_LEN  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic        ok;
		logic        err;
		logic [31:0] distance;
		logic [15:0] code;
	} verdict_t;

endpackage

`default_nettype wire

// File: hdl/laser_range_frame_parser_top.sv
// Parses laser range sensor reply frames presented one byte per transaction, with last_byte
// marking the final byte, and returns one result transaction per frame. Each byte is taken
// into an input register and checked against the per-frame state when it leaves that register,
// so a byte can be accepted every clock unless the input stalls, and the result is loaded into
// the result register as the final byte leaves the input register. The input stalls only while
// a final byte waits behind a result that has not been taken from the result register.
// Accepted frames update the kept distance or error code and the frame counter; the result
// outputs other than frame_ok always show the kept values. Write the configuration registers only while idle.
`default_nettype none

module laser_range_frame_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             frame_ok,
	output logic             error_kept,
	output logic             result_valid,
	output logic signed [31:0] meas_distance,
	output logic [15:0]      error_code,
	output logic [31:0]      good_count,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);
	import lrfp_pkg::*;

	logic [7:0] dev_addr_val_q;
	logic [7:0] max_len_q;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       advance;
	logic       load_out;

	logic        out_valid_q;
	logic        frame_ok_q;
	logic        is_error_q;
	logic        result_valid_q;
	logic [31:0] distance_q;
	logic [15:0] code_q;
	logic [31:0] count_q;

	verdict_t verdict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_val_q <= '0;
			max_len_q      <= MAX_LEN_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEVICE_ADDRESS: dev_addr_val_q <= cfg_data;
				REG_MAX_FRAME_LEN:  max_len_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign load_out = advance && last_s1;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= rx_byte;
			last_s1 <= last_byte;
		end
	end

	lrfp_frame_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.data     (data_s1),
		.last     (last_s1),
		.dev_addr (dev_addr_val_q),
		.max_len  (max_len_q),
		.verdict  (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			frame_ok_q     <= 1'b0;
			is_error_q     <= 1'b0;
			result_valid_q <= 1'b0;
			distance_q     <= '0;
			code_q         <= '0;
			count_q        <= '0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (load_out) begin
				frame_ok_q <= verdict.ok;
				if (verdict.ok) begin
					is_error_q     <= verdict.err;
					result_valid_q <= 1'b1;
					distance_q     <= verdict.distance;
					code_q         <= verdict.code;
					count_q        <= count_q + 32'd1;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_ok      = frame_ok_q;
	assign error_kept    = is_error_q;
	assign result_valid  = result_valid_q;
	assign meas_distance = distance_q;
	assign error_code    = code_q;
	assign good_count    = count_q;

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && verdict.ok) |=> count_q == $past(count_q) + 32'd1)
		else $error("frame counter did not advance on an accepted frame");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(load_out && verdict.ok) |=> count_q == $past(count_q))
		else $error("frame counter changed without an accepted frame");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		is_error_q |-> distance_q == 32'd0)
		else $error("error result carries a distance");

	a_meas_fields: assert property (@(posedge clk) disable iff (!arst_n)
		!is_error_q |-> code_q == 16'd0)
		else $error("measurement result carries an error code");

	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid_q |-> (count_q == 32'd0 && distance_q == 32'd0 && !is_error_q))
		else $error("kept result present before any accepted frame");

endmodule

`default_nettype wire

// File: hdl/lrfp_frame_track.sv
`default_nettype none

module lrfp_frame_track (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire logic [7:0]        data,
	input  wire logic              last,
	input  wire logic [7:0]        dev_addr,
	input  wire logic [7:0]        max_len,
	output lrfp_pkg::verdict_t     verdict
);
	import lrfp_pkg::*;

	logic [7:0]  idx_q;
	logic [7:0]  sum_q;
	logic        hdr_q;
	logic        err_q;
	logic [31:0] dist_q;
	logic [15:0] code_q;

	logic        hdr_nxt;
	logic        err_nxt;
	logic [31:0] dist_nxt;
	logic [15:0] code_nxt;
	logic        len_ok;

	always_comb begin
		hdr_nxt  = hdr_q;
		err_nxt  = err_q;
		dist_nxt = dist_q;
		code_nxt = code_q;
		unique case (idx_q)
			IDX_HEAD: begin
				err_nxt = (data == HEAD_ERR);
				hdr_nxt = (data == HEAD_MEAS);
			end
			IDX_ADDR: begin
				if (data != dev_addr) hdr_nxt = 1'b0;
			end
			IDX_ZERO: begin
				if (data != ZERO_BYTE) hdr_nxt = 1'b0;
			end
			IDX_CMD: begin
				if (data != CMD_BYTE) hdr_nxt = 1'b0;
			end
			default: begin
			end
		endcase
		if (idx_q >= IDX_DIST_FIRST && idx_q <= IDX_DIST_LAST) begin
			dist_nxt = {dist_q[23:0], data};
		end
		if (idx_q >= IDX_CODE_FIRST && idx_q <= IDX_CODE_LAST) begin
			code_nxt = {code_q[7:0], data};
		end
	end

	always_comb begin
		len_ok = (idx_q != IDX_SAT) && (idx_q >= IDX_MIN_LAST) && (idx_q < max_len);
		verdict = '0;
		if (len_ok && err_nxt) begin
			verdict.ok   = 1'b1;
			verdict.err  = 1'b1;
			verdict.code = code_nxt;
		end else if (len_ok && hdr_nxt && idx_q >= IDX_MEAS_MIN_LAST && sum_q == data) begin
			verdict.ok       = 1'b1;
			verdict.distance = dist_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			sum_q  <= '0;
			hdr_q  <= 1'b1;
			err_q  <= 1'b0;
			dist_q <= '0;
			code_q <= '0;
		end else if (step) begin
			if (last) begin
				idx_q  <= '0;
				sum_q  <= '0;
				hdr_q  <= 1'b1;
				err_q  <= 1'b0;
				dist_q <= '0;
				code_q <= '0;
			end else begin
				hdr_q  <= hdr_nxt;
				err_q  <= err_nxt;
				dist_q <= dist_nxt;
				code_q <= code_nxt;
				if (idx_q != IDX_HEAD) sum_q <= sum_q + data;
				if (idx_q != IDX_SAT) idx_q <= idx_q + 8'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: test/frame_verdict_monitor.sv
`default_nettype none

module frame_verdict_monitor (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               last_byte,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic               frame_ok,
	input  wire logic               error_kept,
	input  wire logic               result_valid,
	input  wire logic signed [31:0] meas_distance,
	input  wire logic [15:0]        error_code,
	input  wire logic [31:0]        good_count,
	input  wire logic               cfg_wr_en,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data,
	output int                      mismatches,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import lrfp_pkg::*;

	typedef struct packed {
		logic               ok;
		logic               err;
		logic               valid;
		logic signed [31:0] distance;
		logic [15:0]        code;
		logic [31:0]        count;
	} frame_verdict_t;

	logic [7:0]         sensor_addr;
	logic [7:0]         len_limit;
	logic [7:0]         pos;
	logic [7:0]         sum;
	logic               header_ok;
	logic               err_report;
	logic [31:0]        dist_shift;
	logic [15:0]        code_shift;
	logic signed [31:0] held_distance;
	logic [15:0]        held_code;
	logic               held_valid;
	logic               held_err;
	logic [31:0]        accepted_frames;
	frame_verdict_t     awaited_verdicts[$];
	int                 flaw_count;

	task automatic clear_frame_state();
		pos = '0;
		sum = '0;
		header_ok = 1'b1;
		err_report = 1'b0;
		dist_shift = '0;
		code_shift = '0;
	endtask

	task automatic parse_rx_byte(input logic [7:0] b, input logic fin);
		frame_verdict_t v;
		logic len_ok;
		logic ok;
		case (pos)
		IDX_HEAD: begin
			err_report = (b == HEAD_ERR);
			header_ok = (b == HEAD_MEAS);
		end
		IDX_ADDR: if (b != sensor_addr) header_ok = 1'b0;
		IDX_ZERO: if (b != ZERO_BYTE) header_ok = 1'b0;
		IDX_CMD: if (b != CMD_BYTE) header_ok = 1'b0;
		default: ;
		endcase
		if (pos >= IDX_DIST_FIRST && pos <= IDX_DIST_LAST)
			dist_shift = {dist_shift[23:0], b};
		if (pos >= IDX_CODE_FIRST && pos <= IDX_CODE_LAST)
			code_shift = {code_shift[7:0], b};
		if (!fin) begin
			if (pos != IDX_HEAD)
				sum = sum + b;
			if (pos != IDX_SAT)
				pos = pos + 8'd1;
		end else begin
			// A frame of idx + 1 bytes fits when idx + 1 <= limit, i.e. idx < limit.
			len_ok = (pos != IDX_SAT) && (pos >= IDX_MIN_LAST) && (pos < len_limit);
			ok = 1'b0;
			if (len_ok && err_report) begin
				ok = 1'b1;
				held_distance = '0;
				held_code = code_shift;
				held_valid = 1'b1;
				held_err = 1'b1;
			end else if (len_ok && header_ok && pos >= IDX_MEAS_MIN_LAST && sum == b) begin
				ok = 1'b1;
				held_distance = dist_shift;
				held_code = '0;
				held_valid = 1'b1;
				held_err = 1'b0;
			end
			if (ok)
				accepted_frames = accepted_frames + 32'd1;
			v = '{ok, held_err, held_valid, held_distance, held_code, accepted_frames};
			awaited_verdicts.push_back(v);
			clear_frame_state();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_verdict_t seen;
		frame_verdict_t want;
		if (!arst_n) begin
			sensor_addr = '0;
			len_limit = MAX_LEN_RESET;
			clear_frame_state();
			held_distance = '0;
			held_code = '0;
			held_valid = 1'b0;
			held_err = 1'b0;
			accepted_frames = '0;
			awaited_verdicts.delete();
			flaw_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index == REG_DEVICE_ADDRESS)
					sensor_addr = cfg_data;
				else
					len_limit = cfg_data;
			end
			if (out_valid && out_ready) begin
				seen = '{frame_ok, error_kept, result_valid, meas_distance, error_code,
					good_count};
				if (awaited_verdicts.size() == 0) begin
					if (flaw_count < 10)
						$display("result transaction with no frame pending: ok=%0b err=%0b",
							seen.ok, seen.err, " valid=%0b dist=%0d code=%04h count=%0d",
							seen.valid, seen.distance, seen.code, seen.count);
					flaw_count++;
				end else begin
					want = awaited_verdicts.pop_front();
					if (seen !== want) begin
						if (flaw_count < 10) begin
							$display("frame verdict mismatch: expected ok=%0b err=%0b valid=%0b",
								want.ok, want.err, want.valid,
								" dist=%0d code=%04h count=%0d",
								want.distance, want.code, want.count);
							$display("                        actual   ok=%0b err=%0b valid=%0b",
								seen.ok, seen.err, seen.valid,
								" dist=%0d code=%04h count=%0d",
								seen.distance, seen.code, seen.count);
						end
						flaw_count++;
					end
				end
			end
			if (in_valid && in_ready)
				parse_rx_byte(rx_byte, last_byte);
			mismatches <= flaw_count;
			pending <= awaited_verdicts.size();
		end
	end

endmodule

`default_nettype wire

// File: test/tb_laser_range_frame_parser_top.sv
`default_nettype none

module tb_laser_range_frame_parser_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lrfp_pkg::*;

	localparam int unsigned RUN_LIMIT = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = '0;
	logic               last_byte = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               frame_ok;
	logic               error_kept;
	logic               result_valid;
	logic signed [31:0] meas_distance;
	logic [15:0]        error_code;
	logic [31:0]        good_count;
	logic               cfg_wr_en = 1'b0;
	cfg_reg_t           cfg_index = REG_DEVICE_ADDRESS;
	logic [7:0]         cfg_data = '0;

	logic               calm = 1'b0;
	int                 fail_count;
	int                 pending_count;
	int unsigned        cycle_count = 0;
	logic [7:0]         addr_now = '0;
	logic [7:0]         max_now = MAX_LEN_RESET;
	logic [7:0]         frame_q[$];

	laser_range_frame_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_ok      (frame_ok),
		.error_kept    (error_kept),
		.result_valid  (result_valid),
		.meas_distance (meas_distance),
		.error_code    (error_code),
		.good_count    (good_count),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	frame_verdict_monitor monitor (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.frame_ok      (frame_ok),
		.error_kept    (error_kept),
		.result_valid  (result_valid),
		.meas_distance (meas_distance),
		.error_code    (error_code),
		.good_count    (good_count),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (fail_count),
		.pending       (pending_count)
	);

	always begin
		#6ns clk = 1'b1;
		#6ns clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		out_ready <= calm || ($urandom_range(99) >= 17);
	end

	initial begin
		wait (cycle_count >= RUN_LIMIT);
		$display("tb_laser_range_frame_parser_top failed");
		$finish;
	end

	task automatic set_regs(input logic [7:0] addr, input logic [7:0] lim);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_DEVICE_ADDRESS;
		cfg_data <= addr;
		@(posedge clk);
		cfg_index <= REG_MAX_FRAME_LEN;
		cfg_data <= lim;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		addr_now = addr;
		max_now = lim;
	endtask

	task automatic seal_checksum();
		logic [7:0] sum;
		sum = '0;
		for (int i = 1; i < frame_q.size() - 1; i++)
			sum = sum + frame_q[i];
		if (frame_q.size() >= 2)
			frame_q[frame_q.size() - 1] = sum;
	endtask

	task automatic build_frame(input logic [7:0] head, input int len, input logic [31:0] payload);
		logic [7:0] b;
		frame_q.delete();
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == int'(IDX_HEAD))
				b = head;
			else if (head == HEAD_MEAS && i == int'(IDX_ADDR))
				b = addr_now;
			else if (head == HEAD_MEAS && i == int'(IDX_ZERO))
				b = ZERO_BYTE;
			else if (head == HEAD_MEAS && i == int'(IDX_CMD))
				b = CMD_BYTE;
			else if (head == HEAD_MEAS && i >= int'(IDX_DIST_FIRST) && i <= int'(IDX_DIST_LAST))
				b = payload[8 * (int'(IDX_DIST_LAST) - i) +: 8];
			else if (head == HEAD_ERR && i >= int'(IDX_CODE_FIRST) && i <= int'(IDX_CODE_LAST))
				b = payload[8 * (int'(IDX_CODE_LAST) - i) +: 8];
			frame_q.push_back(b);
		end
		if (head == HEAD_MEAS)
			seal_checksum();
	endtask

	task automatic send_rx_byte(input logic [7:0] b, input logic fin);
		if (!calm && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (!calm && $urandom_range(99) < 17);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_q.size(); i++)
			send_rx_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_frames(input int budget);
		int sent;
		int len;
		int pick;
		int lr;
		int lim;
		logic [7:0] head;
		sent = 0;
		lim = max_now;
		while (sent < budget) begin
			pick = $urandom_range(99);
			lr = $urandom_range(99);
			if (lr < 80)
				len = $urandom_range(13, 24);
			else if (lr < 92)
				len = $urandom_range(1, 12);
			else
				len = $urandom_range(lim < 3 ? 1 : lim - 2, lim + 2);
			if (pick < 55 || (pick >= 70 && pick < 90))
				head = HEAD_MEAS;
			else if (pick < 70)
				head = HEAD_ERR;
			else
				head = 8'($urandom);
			build_frame(head, len, $urandom);
			// A single flipped byte breaks the header or the checksum.
			if (pick >= 70 && pick < 90)
				frame_q[$urandom_range(0, len - 1)] ^= 8'($urandom_range(1, 255));
			send_frame();
			sent += len;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_frame(HEAD_MEAS, 13, 32'h7FFF_FFFF);
		send_frame();
		build_frame(HEAD_MEAS, 13, 32'h8000_0000);
		send_frame();
		build_frame(HEAD_ERR, 9, 32'h0000_FFFF);
		send_frame();
		build_frame(HEAD_MEAS, 12, $urandom);
		send_frame();
		build_frame(HEAD_ERR, 8, $urandom);
		send_frame();
		build_frame(HEAD_MEAS, 64, $urandom);
		send_frame();
		build_frame(HEAD_MEAS, 65, $urandom);
		send_frame();
		build_frame(HEAD_MEAS, 16, $urandom);
		frame_q[15] ^= 8'h01;
		send_frame();
		for (int k = int'(IDX_ADDR); k <= int'(IDX_CMD); k++) begin
			build_frame(HEAD_MEAS, 14, $urandom);
			frame_q[k] ^= 8'h5A;
			seal_checksum();
			send_frame();
		end
		build_frame(8'h55, 13, $urandom);
		send_frame();
		build_frame(HEAD_MEAS, 1, $urandom);
		send_frame();
		build_frame(HEAD_ERR, 20, 32'h0000_0000);
		send_frame();
		settle();

		for (int p = 0; p < 6; p++) begin
			case (p)
			0: set_regs(8'hFF, 8'd255);
			1: set_regs(8'h00, 8'd9);
			2: set_regs(8'($urandom), 8'd8);
			3: set_regs(8'($urandom), 8'($urandom_range(13, 40)));
			4: set_regs(8'($urandom), 8'd0);
			default: set_regs(8'($urandom), MAX_LEN_RESET);
			endcase
			calm <= (p == 3);
			if (p == 0) begin
				// The byte index saturates, so frames of 256 bytes or more must fail.
				build_frame(HEAD_MEAS, 255, $urandom);
				send_frame();
				build_frame(HEAD_ERR, 256, $urandom);
				send_frame();
			end
			random_frames(130);
			settle();
		end

		if (fail_count == 0 && pending_count == 0)
			$display("tb_laser_range_frame_parser_top passed");
		else
			$display("tb_laser_range_frame_parser_top failed");
		$finish;
	end

endmodule

`default_nettype wire
